[hdl/dpse_pkg.sv]
// Shared types, constants and GF(2^8) helpers for the dual parity syndrome engine.
`timescale 1ns / 1ps
`default_nettype none

package dpse_pkg;

   localparam int MAX_DISKS = 32;

   // x^8 + x^4 + x^3 + x^2 + 1
   localparam logic [8:0] GF_POLY = 9'h11D;

   localparam int QUEUE_DEPTH = 4;
   localparam int QUEUE_PTR_W = 2;
   localparam int QUEUE_CNT_W = 3;

   typedef enum logic [1:0] {
      MODE_ENCODE   = 2'd0,
      MODE_DATA_Q   = 2'd1,
      MODE_DATA_P   = 2'd2,
      MODE_TWO_DATA = 2'd3
   } mode_type;

   typedef enum logic [1:0] {
      KIND_DATA = 2'd0,
      KIND_P    = 2'd1,
      KIND_Q    = 2'd2,
      KIND_NONE = 2'd3
   } kind_type;

   typedef enum logic [1:0] {
      CSR_MODE          = 2'd0,
      CSR_FAILED_FIRST  = 2'd1,
      CSR_FAILED_SECOND = 2'd2
   } csr_index_type;

   typedef struct packed {
      mode_type   mode;
      logic [4:0] failed_first;
      logic [4:0] failed_second;
   } dpse_cfg_type;

   // one classified beat, as it travels from front to back
   typedef struct packed {
      logic       keep;      // data byte that goes into the sums
      logic       is_p;
      logic       is_q;
      logic [7:0] value;
      logic [7:0] weighted;  // g^index * value
      logic       last;
   } dpse_item_type;

   typedef logic [7:0] byte_table_type [256];

   function automatic logic [7:0] gf_xtime(input logic [7:0] v);
      logic [7:0] s;
      s = {v[6:0], 1'b0};
      return v[7] ? (s ^ GF_POLY[7:0]) : s;
   endfunction

   function automatic logic [7:0] gf_mul(input logic [7:0] a, input logic [7:0] b);
      logic [7:0] acc;
      logic [7:0] x;
      acc = 8'd0;
      x   = a;
      for (int k = 0; k < 8; k++) begin
         if (b[k]) begin
            acc = acc ^ x;
         end
         x = gf_xtime(x);
      end
      return acc;
   endfunction

   // g^k for k = 0..255 (entry 255 wraps to 1)
   function automatic byte_table_type gf_exp_build();
      byte_table_type t;
      logic [7:0]     v;
      v = 8'd1;
      for (int k = 0; k < 256; k++) begin
         t[k] = v;
         v    = gf_xtime(v);
      end
      return t;
   endfunction

   // inverse of every element; zero maps to zero
   function automatic byte_table_type gf_inv_build();
      byte_table_type t;
      byte_table_type e;
      e = gf_exp_build();
      t = '{default: 8'd0};
      for (int k = 0; k < 255; k++) begin
         t[e[k]] = (k == 0) ? e[0] : e[255 - k];
      end
      return t;
   endfunction

   localparam byte_table_type GF_EXP = gf_exp_build();
   localparam byte_table_type GF_INV = gf_inv_build();

endpackage

`default_nettype wire

[hdl/dpse_front.sv]
// Front end: classifies an incoming beat and forms its weighted contribution.
`timescale 1ns / 1ps
`default_nettype none

module dpse_front
   import dpse_pkg::*;
(
   input  wire dpse_cfg_type  cfg,
   input  wire logic [1:0]    kind,
   input  wire logic [4:0]    disk_index,
   input  wire logic [7:0]    byte_value,
   input  wire logic          stripe_end,
   output dpse_item_type      item
);

   logic skip;
   logic is_data;

   always_comb begin
      is_data = (kind == KIND_DATA);
      skip    = 1'b0;
      if (int'(disk_index) >= MAX_DISKS) begin
         skip = 1'b1;
      end
      if (cfg.mode != MODE_ENCODE && disk_index == cfg.failed_first) begin
         skip = 1'b1;
      end
      if (cfg.mode == MODE_TWO_DATA && disk_index == cfg.failed_second) begin
         skip = 1'b1;
      end

      item.keep     = is_data && !skip;
      item.is_p     = (kind == KIND_P);
      item.is_q     = (kind == KIND_Q);
      item.value    = byte_value;
      item.weighted = gf_mul(GF_EXP[{3'b000, disk_index}], byte_value);
      item.last     = stripe_end;
   end

endmodule

`default_nettype wire

[hdl/dpse_queue.sv]
// Short queue of classified beats between front and back.
`timescale 1ns / 1ps
`default_nettype none

module dpse_queue
   import dpse_pkg::*;
(
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          in_valid,
   output logic               in_ready,
   input  wire dpse_item_type in_item,
   output logic               out_valid,
   input  wire logic          out_ready,
   output dpse_item_type      out_item
);

   dpse_item_type            entry_ff [QUEUE_DEPTH];
   logic [QUEUE_PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [QUEUE_PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [QUEUE_CNT_W-1:0]   count_ff, count_in;
   logic                     push;
   logic                     pop;

   assign in_ready  = (count_ff != QUEUE_CNT_W'(QUEUE_DEPTH));
   assign out_valid = (count_ff != '0);
   assign out_item  = entry_ff[rd_ptr_ff];
   assign push      = in_valid && in_ready;
   assign pop       = out_valid && out_ready;

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + QUEUE_PTR_W'(1) : wr_ptr_ff;
      rd_ptr_in = pop ? rd_ptr_ff + QUEUE_PTR_W'(1) : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + QUEUE_CNT_W'(1);
      end else if (pop && !push) begin
         count_in = count_ff - QUEUE_CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= in_item;
      end
   end

   assert property (@(posedge clock) disable iff (reset)
      count_ff <= QUEUE_CNT_W'(QUEUE_DEPTH))
      else $error("queue count beyond depth");

   assert property (@(posedge clock) disable iff (reset)
      (count_ff == QUEUE_CNT_W'(QUEUE_DEPTH)) |-> (wr_ptr_ff == rd_ptr_ff))
      else $error("queue full with pointers apart");

   assert property (@(posedge clock) disable iff (reset)
      (push && !pop) |=> (count_ff == $past(count_ff) + QUEUE_CNT_W'(1)))
      else $error("queue count missed a push");

endmodule

`default_nettype wire

[hdl/dpse_back.sv]
// Back end: accumulates P/Q syndromes and solves the stripe result.
`timescale 1ns / 1ps
`default_nettype none

module dpse_back
   import dpse_pkg::*;
(
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire dpse_cfg_type  cfg,
   input  wire logic          item_valid,
   output logic               item_ready,
   input  wire dpse_item_type item,
   output logic               rsp_valid,
   input  wire logic          rsp_ready,
   output logic [7:0]         rsp_first_byte,
   output logic [7:0]         rsp_second_byte,
   output logic               rsp_index_error
);

   typedef enum logic [1:0] {
      ST_ACCUM,
      ST_SOLVE,
      ST_PRODUCT
   } state_type;

   state_type  state_ff, state_in;
   logic [7:0] parity_sum_ff, parity_sum_in;
   logic [7:0] weighted_sum_ff, weighted_sum_in;
   logic [7:0] stored_p_ff, stored_p_in;
   logic [7:0] stored_q_ff, stored_q_in;
   logic [7:0] mul_a_ff, mul_a_in;
   logic [7:0] mul_b_ff, mul_b_in;
   logic       rsp_valid_ff, rsp_valid_in;
   logic [7:0] first_ff, first_in;
   logic [7:0] second_ff, second_in;
   logic       error_ff, error_in;

   logic       pop;
   logic       out_free;
   logic [7:0] pd;
   logic [7:0] qd;
   logic [7:0] g_first;
   logic [7:0] g_second;
   logic [7:0] product;

   assign item_ready      = (state_ff == ST_ACCUM);
   assign pop             = item_valid && item_ready;
   assign out_free        = !rsp_valid_ff || rsp_ready;
   assign rsp_valid       = rsp_valid_ff;
   assign rsp_first_byte  = first_ff;
   assign rsp_second_byte = second_ff;
   assign rsp_index_error = error_ff;

   always_comb begin
      pd       = stored_p_ff ^ parity_sum_ff;
      qd       = stored_q_ff ^ weighted_sum_ff;
      g_first  = GF_EXP[{3'b000, cfg.failed_first}];
      g_second = GF_EXP[{3'b000, cfg.failed_second}];
      product  = gf_mul(mul_a_ff, mul_b_ff);

      state_in        = state_ff;
      parity_sum_in   = parity_sum_ff;
      weighted_sum_in = weighted_sum_ff;
      stored_p_in     = stored_p_ff;
      stored_q_in     = stored_q_ff;
      mul_a_in        = mul_a_ff;
      mul_b_in        = mul_b_ff;
      rsp_valid_in    = rsp_valid_ff && !rsp_ready;
      first_in        = first_ff;
      second_in       = second_ff;
      error_in        = error_ff;

      case (state_ff)
         ST_ACCUM: begin
            if (pop) begin
               if (item.keep) begin
                  parity_sum_in   = parity_sum_ff ^ item.value;
                  weighted_sum_in = weighted_sum_ff ^ item.weighted;
               end
               if (item.is_p) begin
                  stored_p_in = item.value;
               end
               if (item.is_q) begin
                  stored_q_in = item.value;
               end
               if (item.last) begin
                  state_in = ST_SOLVE;
               end
            end
         end
         ST_SOLVE: begin
            // set up the one product the mode needs
            case (cfg.mode)
               MODE_DATA_Q: begin
                  mul_a_in = pd;
                  mul_b_in = g_first;
               end
               MODE_DATA_P: begin
                  mul_a_in = qd;
                  mul_b_in = GF_INV[g_first];
               end
               MODE_TWO_DATA: begin
                  mul_a_in = gf_mul(g_second, pd) ^ qd;
                  mul_b_in = GF_INV[g_first ^ g_second];
               end
               default: begin
                  mul_a_in = 8'd0;
                  mul_b_in = 8'd0;
               end
            endcase
            state_in = ST_PRODUCT;
         end
         ST_PRODUCT: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               error_in     = 1'b0;
               case (cfg.mode)
                  MODE_DATA_Q: begin
                     first_in  = pd;
                     second_in = weighted_sum_ff ^ product;
                  end
                  MODE_DATA_P: begin
                     first_in  = product;
                     second_in = parity_sum_ff ^ product;
                  end
                  MODE_TWO_DATA: begin
                     if (cfg.failed_first == cfg.failed_second) begin
                        first_in  = 8'd0;
                        second_in = 8'd0;
                        error_in  = 1'b1;
                     end else begin
                        first_in  = product;
                        second_in = product ^ pd;
                     end
                  end
                  default: begin
                     first_in  = parity_sum_ff;
                     second_in = weighted_sum_ff;
                  end
               endcase
               parity_sum_in   = 8'd0;
               weighted_sum_in = 8'd0;
               stored_p_in     = 8'd0;
               stored_q_in     = 8'd0;
               state_in        = ST_ACCUM;
            end
         end
         default: begin
            state_in = ST_ACCUM;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff        <= ST_ACCUM;
         parity_sum_ff   <= 8'd0;
         weighted_sum_ff <= 8'd0;
         stored_p_ff     <= 8'd0;
         stored_q_ff     <= 8'd0;
         rsp_valid_ff    <= 1'b0;
      end else begin
         state_ff        <= state_in;
         parity_sum_ff   <= parity_sum_in;
         weighted_sum_ff <= weighted_sum_in;
         stored_p_ff     <= stored_p_in;
         stored_q_ff     <= stored_q_in;
         rsp_valid_ff    <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      mul_a_ff  <= mul_a_in;
      mul_b_ff  <= mul_b_in;
      first_ff  <= first_in;
      second_ff <= second_in;
      error_ff  <= error_in;
   end

   assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SOLVE) |=> (state_ff == ST_PRODUCT))
      else $error("solve step not followed by product step");

   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && error_ff) |-> (first_ff == 8'd0 && second_ff == 8'd0))
      else $error("index error beat carries data");

   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && error_ff) |-> (cfg.mode == MODE_TWO_DATA))
      else $error("index error outside two-data mode");

   assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_PRODUCT && out_free) |=>
         (parity_sum_ff == 8'd0 && weighted_sum_ff == 8'd0 &&
          stored_p_ff == 8'd0 && stored_q_ff == 8'd0 && rsp_valid_ff))
      else $error("stripe state not cleared after result");

endmodule

`default_nettype wire

[hdl/dual_parity_syndrome_engine_top.sv]
// Top level of the dual parity (P/Q over GF(2^8)) syndrome engine.
// Path: a stripe_end beat is written into the queue and popped by the accumulate step;
//   the back end then passes its solve and product steps before the result is shown.
// Throughput: one beat per cycle, set by the single-beat accumulate step of the back end;
//   each stripe_end beat holds the back end for its solve and product steps, longer
//   while the previous result still waits on rsp_tready.
// Reset (synchronous, active high) clears the queue, the sums, the output valid
//   and the registers to mode 0, failed_first 0, failed_second 1.
`timescale 1ns / 1ps
`default_nettype none

module dual_parity_syndrome_engine_top
   import dpse_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [15:0] req_tdata,   // [4:0] disk_index, [12:5] byte_value, [15:13] zero
   input  wire logic [1:0]  req_tuser,   // [1:0] kind
   input  wire logic        req_tlast,   // stripe_end
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [15:0]      rsp_tdata,   // [7:0] first_byte, [15:8] second_byte
   output logic             rsp_tuser,   // [0] index_error
   input  wire logic        csr_valid,
   output logic             csr_ready,
   input  wire logic [1:0]  csr_index,
   input  wire logic [4:0]  csr_data
);

   dpse_cfg_type  cfg_ff, cfg_in;
   dpse_item_type front_item;
   dpse_item_type queue_item;
   logic          queue_valid;
   logic          queue_ready;
   logic [7:0]    first_byte;
   logic [7:0]    second_byte;

   assign csr_ready = 1'b1;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         case (csr_index)
            CSR_MODE:          cfg_in.mode          = mode_type'(csr_data[1:0]);
            CSR_FAILED_FIRST:  cfg_in.failed_first  = csr_data;
            CSR_FAILED_SECOND: cfg_in.failed_second = csr_data;
            default: begin
               cfg_in = cfg_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.mode          <= MODE_ENCODE;
         cfg_ff.failed_first  <= 5'd0;
         cfg_ff.failed_second <= 5'd1;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   dpse_front u_front (
      .cfg        (cfg_ff),
      .kind       (req_tuser),
      .disk_index (req_tdata[4:0]),
      .byte_value (req_tdata[12:5]),
      .stripe_end (req_tlast),
      .item       (front_item)
   );

   dpse_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_tvalid),
      .in_ready  (req_tready),
      .in_item   (front_item),
      .out_valid (queue_valid),
      .out_ready (queue_ready),
      .out_item  (queue_item)
   );

   dpse_back u_back (
      .clock           (clock),
      .reset           (reset),
      .cfg             (cfg_ff),
      .item_valid      (queue_valid),
      .item_ready      (queue_ready),
      .item            (queue_item),
      .rsp_valid       (rsp_tvalid),
      .rsp_ready       (rsp_tready),
      .rsp_first_byte  (first_byte),
      .rsp_second_byte (second_byte),
      .rsp_index_error (rsp_tuser)
   );

   assign rsp_tdata = {second_byte, first_byte};

endmodule

`default_nettype wire
